// File: rtl/core/vms_pkg.sv
// vms_pkg: shared constants, types and the abs32 helper of the vector magnitude scaler
// used by every module under rtl/core
package vms_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 32;
  localparam logic [31:0] ONE_FIX = 32'(64'd1 << FRAC_BITS);

  typedef enum logic [1:0] {
    FN_PASS = 2'd0,
    FN_NORM = 2'd1,
    FN_LIMIT = 2'd2,
    FN_SET = 2'd3
  } func_t;

  typedef struct packed {
    func_t            func;
    logic [31:0]      x;
    logic [31:0]      y;
    logic [31:0]      z;
    logic [31:0]      s_abs;
    logic             s_neg;
    logic [2:0]       c_neg;
    logic [2:0][63:0] prod;
    logic [63:0]      sq;
  } fe_side_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [2:0]  neg;
    logic        scale;
    logic [31:0] mag;
    logic [63:0] sq;
  } dv_side_t;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? 32'(~v + 32'd1) : v;
  endfunction

endpackage

// File: rtl/core/vector_magnitude_scaler.sv
// vector_magnitude_scaler: 3d vector magnitude, pass, normalize, limit and set magnitude
// top level; depends on vms_pkg, vms_front, vms_sqrt and vms_div
//
// input channel in_*: one item per vector, in_tuser carries the operation
// selector, in_tdata the three signed components and the scalar.
// output channel out_*: one item per input item, in the same order, with the
// rescaled vector, the magnitude and the squared magnitude.
// throughput: one item per cycle while the output is not stalled; from acceptance
// to out_tvalid an item passes 3 front stages, 32 root stages, 1 decision stage,
// 32 divider stages and 1 output register.
// the whole pipeline advances together: it moves whenever the output
// register is empty or being taken, so in_tready is low only while a
// finished item sits in the output register and out_tready is low.
// a stall holds every stage, nothing is lost or repeated.
// reset clears all valid bits; the first item may be sent in the cycle
// after rst_n rises.
module vector_magnitude_scaler import vms_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // in_x, in_y, in_z, scalar
  input  logic [1:0]   in_tuser,   // func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata   // out_x, out_y, out_z, magnitude, mag_squared
);

  logic             adv;
  logic             fe_vld, sq_vld, dv_vld;
  fe_side_t         fe_side, sq_side;
  logic [31:0]      sq_root;
  logic             dc_vld_r;
  dv_side_t         dc_side_r, dc_side_nxt, dv_side;
  logic [2:0][63:0] dc_num_r;
  logic [2:0][31:0] dv_quo;
  logic             out_vld_r;
  logic [191:0]     out_data_r, out_data_nxt;
  logic             scale;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  vms_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_tvalid),
    .in_func  (func_t'(in_tuser)),
    .in_x     (in_tdata[31:0]),
    .in_y     (in_tdata[63:32]),
    .in_z     (in_tdata[95:64]),
    .in_s     (in_tdata[127:96]),
    .out_vld  (fe_vld),
    .out_side (fe_side)
  );

  vms_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (fe_vld),
    .in_side  (fe_side),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  always_comb begin
    case (sq_side.func)
      FN_NORM:  scale = 1'b1;
      FN_LIMIT: scale = sq_side.s_neg || (sq_root > sq_side.s_abs);
      FN_SET:   scale = 1'b1;
      default:  scale = 1'b0;
    endcase
    dc_side_nxt.x     = sq_side.x;
    dc_side_nxt.y     = sq_side.y;
    dc_side_nxt.z     = sq_side.z;
    dc_side_nxt.scale = scale && (sq_root != '0);
    dc_side_nxt.neg   = (sq_side.func == FN_NORM) ? sq_side.c_neg
                                                  : sq_side.c_neg ^ {3{sq_side.s_neg}};
    dc_side_nxt.mag   = sq_root;
    dc_side_nxt.sq    = sq_side.sq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_vld_r <= 1'b0;
    end else if (adv) begin
      dc_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dc_side_r <= dc_side_nxt;
      dc_num_r  <= sq_side.prod;
    end
  end

  vms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (dc_vld_r),
    .in_num   (dc_num_r),
    .in_side  (dc_side_r),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  always_comb begin
    logic [2:0][31:0] raw;
    logic [2:0][31:0] vec;
    raw = {dv_side.z, dv_side.y, dv_side.x};
    for (int i = 0; i < 3; i++) begin
      if (!dv_side.scale) begin
        vec[i] = raw[i];
      end else if (dv_side.neg[i]) begin
        vec[i] = 32'(~dv_quo[i] + 32'd1);
      end else begin
        vec[i] = dv_quo[i][31] ? 32'h7FFF_FFFF : dv_quo[i];
      end
    end
    out_data_nxt = {dv_side.sq, dv_side.mag, vec[2], vec[1], vec[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (64'(out_tdata[127:96]) * 64'(out_tdata[127:96]) <= out_tdata[191:128]))
    else $error("magnitude squared exceeds squared magnitude");

  a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((66'(out_tdata[127:96]) + 66'd1) * (66'(out_tdata[127:96]) + 66'd1)
                    > 66'(out_tdata[191:128])))
    else $error("magnitude below floor of square root");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready ##1 (out_tvalid && $stable(out_tdata)))
    else $error("stalled item changed or pipeline advanced");

  a_zero_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld && dv_side.mag == '0) |-> !dv_side.scale)
    else $error("zero vector marked for rescaling");

endmodule

// File: rtl/core/vms_front.sv
// vms_front: absolute values, squares, scaled products and sum of squares
// three register stages; depends on vms_pkg
module vms_front import vms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_vld,
  input  func_t       in_func,
  input  logic [31:0] in_x,
  input  logic [31:0] in_y,
  input  logic [31:0] in_z,
  input  logic [31:0] in_s,
  output logic        out_vld,
  output fe_side_t    out_side
);

  logic [2:0]       a_vld_r;
  logic [2:0][31:0] a_abs_r;
  logic [31:0]      a_t_r;
  fe_side_t         a_side_r, b_side_r, c_side_r;
  fe_side_t         a_side_nxt, b_side_nxt, c_side_nxt;
  logic [2:0][63:0] b_sqr_r;
  logic [2:0][31:0] raw;

  assign raw = {in_z, in_y, in_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= '0;
    end else if (adv) begin
      a_vld_r <= {a_vld_r[1:0], in_vld};
    end
  end

  always_comb begin
    a_side_nxt       = '0;
    a_side_nxt.func  = in_func;
    a_side_nxt.x     = in_x;
    a_side_nxt.y     = in_y;
    a_side_nxt.z     = in_z;
    a_side_nxt.s_abs = abs32(in_s);
    a_side_nxt.s_neg = in_s[31];
    a_side_nxt.c_neg = {in_z[31], in_y[31], in_x[31]};

    b_side_nxt = a_side_r;
    for (int i = 0; i < 3; i++) begin
      b_side_nxt.prod[i] = 64'(a_abs_r[i]) * 64'(a_t_r);
    end

    c_side_nxt    = b_side_r;
    c_side_nxt.sq = b_sqr_r[0] + b_sqr_r[1] + b_sqr_r[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_abs_r[i] <= abs32(raw[i]);
      end
      a_side_r <= a_side_nxt;
      a_t_r    <= (in_func == FN_NORM) ? ONE_FIX : abs32(in_s);

      b_side_r <= b_side_nxt;
      for (int i = 0; i < 3; i++) begin
        b_sqr_r[i] <= 64'(a_abs_r[i]) * 64'(a_abs_r[i]);
      end

      c_side_r <= c_side_nxt;
    end
  end

  assign out_vld  = a_vld_r[2];
  assign out_side = c_side_r;

endmodule

// File: rtl/core/vms_sqrt.sv
// vms_sqrt: pipelined integer square root of the squared magnitude
// one root bit per stage; depends on vms_pkg
module vms_sqrt import vms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_vld,
  input  fe_side_t    in_side,
  output logic        out_vld,
  output logic [31:0] out_root,
  output fe_side_t    out_side
);

  logic [SQ_STEPS-1:0] vld_r;
  logic [32:0]         rem_r  [SQ_STEPS];
  logic [31:0]         root_r [SQ_STEPS];
  logic [63:0]         n_r    [SQ_STEPS];
  fe_side_t            side_r [SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[SQ_STEPS-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [32:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] n_in;
    fe_side_t    side_in;
    logic [34:0] acc;
    logic [34:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = in_side.sq;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign n_in    = n_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign acc   = {rem_in, n_in[63:62]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = acc >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? 33'(acc - trial) : acc[32:0];
        root_r[k] <= {root_in[30:0], ge};
        n_r[k]    <= {n_in[61:0], 2'b00};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[SQ_STEPS-1];
  assign out_root = root_r[SQ_STEPS-1];
  assign out_side = side_r[SQ_STEPS-1];

endmodule

// File: rtl/core/vms_div.sv
// vms_div: three-lane pipelined restoring divider, product by magnitude
// one quotient bit per stage; depends on vms_pkg
module vms_div import vms_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_vld,
  input  logic [2:0][63:0] in_num,
  input  dv_side_t         in_side,
  output logic             out_vld,
  output logic [2:0][31:0] out_quo,
  output dv_side_t         out_side
);

  logic [DIV_STEPS-1:0] vld_r;
  logic [2:0][31:0]     rem_r  [DIV_STEPS];
  logic [2:0][31:0]     quo_r  [DIV_STEPS];
  logic [2:0][31:0]     num_r  [DIV_STEPS];
  dv_side_t             side_r [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DIV_STEPS-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [2:0][31:0] rem_in, quo_in, num_in;
    dv_side_t         side_in;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = in_num[l][63:32];
        assign num_in[l] = in_num[l][31:0];
      end
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign num_in  = num_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          if ({rem_in[l], num_in[l][31]} >= {1'b0, side_in.mag}) begin
            rem_r[k][l] <= 32'({rem_in[l], num_in[l][31]} - {1'b0, side_in.mag});
            quo_r[k][l] <= {quo_in[l][30:0], 1'b1};
          end else begin
            rem_r[k][l] <= {rem_in[l][30:0], num_in[l][31]};
            quo_r[k][l] <= {quo_in[l][30:0], 1'b0};
          end
          num_r[k][l] <= {num_in[l][30:0], 1'b0};
        end
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[DIV_STEPS-1];
  assign out_quo  = quo_r[DIV_STEPS-1];
  assign out_side = side_r[DIV_STEPS-1];

endmodule

// File: verif/vms_checker.sv
// vms_checker: watches both streams of vector_magnitude_scaler, predicts each result
// from the accepted vector and compares field by field; depends on vms_pkg
module vms_checker import vms_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [191:0] out_tdata,
  output int           errors,
  output int           pending,
  output int           results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [191:0] expected_q[$];

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] to_signed32(input logic neg, input logic [63:0] m);
    if (neg) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'(64'h1_0000_0000 - m);
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return m[31:0];
  endfunction

  function automatic logic [191:0] scaled_vector(input func_t fn, input logic [127:0] d);
    logic [31:0] comp[3];
    logic [63:0] mag_abs[3];
    logic [63:0] sq;
    logic [63:0] mag;
    logic [63:0] s_m;
    logic        s_n;
    logic [63:0] t_m;
    logic        t_n;
    logic        do_scale;
    logic [31:0] res[3];
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      comp[i] = d[32*i +: 32];
      mag_abs[i] = comp[i][31] ? 64'h1_0000_0000 - comp[i] : 64'(comp[i]);
      sq = sq + mag_abs[i] * mag_abs[i];
    end
    mag = root64(sq);
    s_n = d[127];
    s_m = s_n ? 64'h1_0000_0000 - d[127:96] : 64'(d[127:96]);
    do_scale = 0;
    t_m = 0;
    t_n = 0;
    if (mag != 0) begin
      case (fn)
        FN_NORM: begin
          do_scale = 1;
          t_m = 64'd1 << FRAC_BITS;
        end
        FN_LIMIT: if (s_n || mag > s_m) begin
          do_scale = 1;
          t_m = s_m;
          t_n = s_n;
        end
        FN_SET: begin
          do_scale = 1;
          t_m = s_m;
          t_n = s_n;
        end
        default: ;
      endcase
    end
    for (int i = 0; i < 3; i++)
      res[i] = do_scale ? to_signed32(comp[i][31] != t_n, (mag_abs[i] * t_m) / mag) : comp[i];
    return {sq, mag[31:0], res[2], res[1], res[0]};
  endfunction

  assign pending = expected_q.size();

  initial begin
    errors = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    logic [191:0] e;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_q.push_back(scaled_vector(func_t'(in_tuser), in_tdata));
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item %h", $time, out_tdata);
        end else begin
          e = expected_q.pop_front();
          for (int f = 0; f < 4; f++)
            if (e[32*f +: 32] !== out_tdata[32*f +: 32]) begin
              errors++;
              $display("%0t: field %0d expected %h got %h", $time, f,
                       e[32*f +: 32], out_tdata[32*f +: 32]);
            end
          if (e[191:128] !== out_tdata[191:128]) begin
            errors++;
            $display("%0t: mag_squared expected %h got %h", $time,
                     e[191:128], out_tdata[191:128]);
          end
        end
      end
    end
  end
endmodule

// File: verif/tb.sv
// tb: stimulus and verdict for vector_magnitude_scaler
// depends on vms_pkg, the block and vms_checker
module tb;
  import vms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // in_x, in_y, in_z, scalar
  logic [1:0]   in_tuser;   // func
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;  // out_x, out_y, out_z, magnitude, mag_squared
  int           errors;
  int           pending;
  int           results_seen;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_cycles;
  int           cycles;
  int           sent;

  localparam int LATENCY = 69;
  localparam int LIMIT = 400000;

  vector_magnitude_scaler u_top (.*);

  vms_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver: random stalls plus one long hold
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 0;
      3: return $urandom_range(3) - 1;
      4: return 32'($signed($urandom_range(65535) - 32768) <<< $urandom_range(16));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vector(input func_t fn, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [31:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= fn;
    in_tdata <= {s, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic random_vectors(input int n);
    for (int i = 0; i < n; i++)
      send_vector(func_t'($urandom_range(3)), rand_comp(), rand_comp(), rand_comp(),
                  ($urandom_range(3) == 0) ? rand_comp() : $urandom_range(32'h7FFF_FFFF));
  endtask

  initial begin
    func_t fn;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = 0;
    out_tready = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    fn = fn.first();
    do begin
      send_vector(fn, 0, 0, 0, 32'h0001_0000);
      send_vector(fn, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(fn, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vector(fn, 32'h0003_0000, 32'hFFFC_0000, 0, 32'h0002_0000);
      send_vector(fn, 32'h0000_0001, 0, 32'hFFFF_FFFF, 32'hFFFF_0000);
      fn = fn.next();
    end while (fn != fn.first());
    send_vector(FN_LIMIT, 32'h0003_0000, 32'h0004_0000, 0, 32'h0005_0000);
    send_vector(FN_SET, 32'h0000_0001, 0, 0, 32'h8000_0000);
    random_vectors(100);
    send_idle_pct = 85;
    random_vectors(100);
    send_idle_pct = 0;
    recv_stall_pct = 85;
    random_vectors(100);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    random_vectors(100);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 300;
    random_vectors(100);
    in_tvalid <= 0;
    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("tb: %0d vectors sent, %0d results checked over all four operations", sent,
             results_seen);
    $display("tb: idle and stall phases plus a long output hold were exercised");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: vector_magnitude_scaler.f
rtl/core/vms_pkg.sv
rtl/core/vms_front.sv
rtl/core/vms_sqrt.sv
rtl/core/vms_div.sv
rtl/core/vector_magnitude_scaler.sv
verif/vms_checker.sv
verif/tb.sv
